### sv/psgc_pkg.sv
// ----------------------------------------------------------------------------
// psgc_pkg
// Shared types and constants for the pressure sensor Gaussian calibration.
// ----------------------------------------------------------------------------
package psgc_pkg;

  localparam int VW    = 12;  // voltage / vref width
  localparam int GNW   = 18;  // gain and pressure width
  localparam int NSW   = 21;  // center / width register width
  localparam int RFW   = 20;  // feedback resistor width
  localparam int CNDW  = 22;  // saturated conductance width
  localparam int DENW  = 32;  // vref * rf
  localparam int NUMW  = 42;  // conductance dividend / quotient
  localparam int GRW   = NUMW + 1;  // unsaturated signed conductance
  localparam int ADW   = NSW + 2;   // |d| below 4 * width
  localparam int XW    = 32;  // Q30 ratio, below 4.0
  localparam int SW    = 30;  // exponent argument
  localparam int RW    = 31;  // Q30 value up to 1.0
  localparam int RCW   = 36;  // reciprocal constant width
  localparam int RCS   = 35;  // reciprocal shift
  localparam int HN    = 12;  // Taylor terms
  localparam int NSQ   = 4;   // squarings
  localparam int CIW   = 3;   // register index width

  localparam logic [29:0] SCALE_NS = 30'd1000000000;
  localparam logic [RW-1:0] Q30_ONE = RW'(1) << 30;
  localparam logic signed [CNDW-1:0] COND_MAX = CNDW'(2097151);
  localparam logic signed [CNDW-1:0] COND_MIN = -CNDW'(2097152);

  // ceil(2^35 / k) for k = 12 down to 1
  localparam logic [RCW-1:0] RECIP [HN] = '{
    36'd2863311531, 36'd3123612579, 36'd3435973837, 36'd3817748708,
    36'd4294967296, 36'd4908534053, 36'd5726623062, 36'd6871947674,
    36'd8589934592, 36'd11453246123, 36'd17179869184, 36'd34359738368
  };

  typedef enum logic [CIW-1:0] {
    REG_GAIN   = 3'd0,
    REG_CENTER = 3'd1,
    REG_WIDTH  = 3'd2,
    REG_VREF   = 3'd3,
    REG_RF     = 3'd4
  } reg_e;

  typedef struct packed {
    logic [GNW-1:0] gain;
    logic [NSW-1:0] center;
    logic [NSW-1:0] width;
    logic [VW-1:0]  vref;
    logic [RFW-1:0] rf;
  } cfg_t;

  typedef struct packed {
    logic signed [GRW-1:0]  g;
    logic signed [CNDW-1:0] cond;
  } item_t;

endpackage

### sv/psgc_fifo.sv
// ----------------------------------------------------------------------------
// psgc_fifo
// Four-entry queue between the conductance front end and the curve back end.
// ----------------------------------------------------------------------------
module psgc_fifo
  import psgc_pkg::*;
(
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  push_i,
  input  item_t push_data_i,
  output logic  full_o,
  input  logic  pop_i,
  output logic  pop_valid_o,
  output item_t pop_data_o
);

  item_t       mem [4];
  logic [1:0]  wr_q, wr_d, rd_q, rd_d;
  logic [2:0]  cnt_q, cnt_d;

  assign full_o      = (cnt_q == 3'd4);
  assign pop_valid_o = (cnt_q != 3'd0);
  assign pop_data_o  = mem[rd_q];

  always_comb begin
    wr_d  = push_i ? wr_q + 2'd1 : wr_q;
    rd_d  = pop_i ? rd_q + 2'd1 : rd_q;
    cnt_d = cnt_q + {2'b0, push_i} - {2'b0, pop_i};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem[wr_q] <= push_data_i;
    end
  end

endmodule

### sv/psgc_front.sv
// ----------------------------------------------------------------------------
// psgc_front
// Accepts voltage samples and forms the signed conductance with a
// one-bit-per-stage divider.
// ----------------------------------------------------------------------------
module psgc_front
  import psgc_pkg::*;
(
  input  logic          clk_i,
  input  logic          rst_ni,
  input  cfg_t          cfg_i,
  input  logic          in_valid_i,
  input  logic [VW-1:0] in_voltage_i,
  output logic          in_ready_o,
  input  logic          full_i,
  output logic          push_o,
  output item_t         push_data_o
);

  logic             ce;
  logic [VW-1:0]    vr;
  logic [RFW-1:0]   rf;
  logic [DENW-1:0]  den_q;

  logic             val0_q;
  logic [VW-1:0]    diff0_q;
  logic             neg0_q;

  logic             val_q  [NUMW+1];
  logic             neg_q  [NUMW+1];
  logic [DENW-1:0]  rem_q  [NUMW+1];
  logic [NUMW-1:0]  num_q  [NUMW+1];
  logic [DENW-1:0]  rem_nx [NUMW];
  logic [NUMW-1:0]  num_nx [NUMW];

  logic [NUMW-1:0]  num_init;
  logic [NUMW-1:0]  q;
  logic signed [GRW-1:0] g;

  assign ce         = !full_i;
  assign in_ready_o = ce;
  assign vr         = (cfg_i.vref == '0) ? VW'(1) : cfg_i.vref;
  assign rf         = (cfg_i.rf == '0) ? RFW'(1) : cfg_i.rf;

  always_ff @(posedge clk_i) begin
    den_q <= DENW'(vr * rf);
  end

  assign num_init = NUMW'(diff0_q * SCALE_NS) + NUMW'(den_q >> 1);

  always_comb begin
    for (int j = 0; j < NUMW; j++) begin
      logic [DENW:0] t;
      logic          ge;
      t         = {rem_q[j], num_q[j][NUMW-1]};
      ge        = (t >= {1'b0, den_q});
      rem_nx[j] = ge ? DENW'(t - {1'b0, den_q}) : t[DENW-1:0];
      num_nx[j] = {num_q[j][NUMW-2:0], ge};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      val0_q <= 1'b0;
      for (int j = 0; j <= NUMW; j++) val_q[j] <= 1'b0;
    end else if (ce) begin
      val0_q   <= in_valid_i;
      val_q[0] <= val0_q;
      for (int j = 0; j < NUMW; j++) val_q[j+1] <= val_q[j];
    end
  end

  always_ff @(posedge clk_i) begin
    if (ce) begin
      neg0_q   <= (in_voltage_i < vr);
      diff0_q  <= (in_voltage_i < vr) ? vr - in_voltage_i : in_voltage_i - vr;
      neg_q[0] <= neg0_q;
      rem_q[0] <= '0;
      num_q[0] <= num_init;
      for (int j = 0; j < NUMW; j++) begin
        neg_q[j+1] <= neg_q[j];
        rem_q[j+1] <= rem_nx[j];
        num_q[j+1] <= num_nx[j];
      end
    end
  end

  assign q = num_q[NUMW];
  assign g = neg_q[NUMW] ? -$signed({1'b0, q}) : $signed({1'b0, q});

  always_comb begin
    push_data_o.g = g;
    if (g > GRW'(COND_MAX)) begin
      push_data_o.cond = COND_MAX;
    end else if (g < GRW'(COND_MIN)) begin
      push_data_o.cond = COND_MIN;
    end else begin
      push_data_o.cond = g[CNDW-1:0];
    end
  end

  assign push_o = ce && val_q[NUMW];

endmodule

### sv/psgc_back.sv
// ----------------------------------------------------------------------------
// psgc_back
// Gaussian curve: ratio divider, Taylor exp pipeline, squarings, gain scale.
// ----------------------------------------------------------------------------
module psgc_back
  import psgc_pkg::*;
(
  input  logic           clk_i,
  input  logic           rst_ni,
  input  cfg_t           cfg_i,
  input  logic           pop_valid_i,
  input  item_t          pop_data_i,
  output logic           pop_o,
  output logic           out_valid_o,
  input  logic           out_ready_i,
  output logic [GNW-1:0] out_pressure_o,
  output logic [CNDW-1:0] out_cond_o
);

  localparam int NSB = XW + 1 + 2 * HN + NSQ + 2;

  typedef struct packed {
    logic                   zero;
    logic signed [CNDW-1:0] cond;
  } sb_t;

  logic             ce;
  logic [NSW-1:0]   w;
  logic signed [GRW:0] d;
  logic [GRW:0]     ad;
  logic             zero;

  logic             sb_val_q [NSB];
  sb_t              sb_q   [NSB];
  logic [NSW-1:0]   rem_q  [XW+1];
  logic [XW-1:0]    num_q  [XW+1];
  logic [NSW-1:0]   rem_nx [XW];
  logic [XW-1:0]    num_nx [XW];

  logic [SW-1:0]    s_q;
  logic [RW-1:0]    p_q    [HN];
  logic [SW-1:0]    ps_q   [HN];
  logic [RW+RCW-1:0] prod_q [HN];
  logic [SW-1:0]    ds_q   [HN];
  logic [RW-1:0]    sq_q   [NSQ];
  logic [GNW+RW-1:0] pm_q;

  logic             out_valid_q;
  logic [GNW-1:0]   out_pressure_q;
  logic [CNDW-1:0]  out_cond_q;

  logic [2*XW-1:0]  xx;
  logic [RW-1:0]    r_exp;
  logic [GNW+RW-1:0] pm_rnd;

  assign ce    = !out_valid_q || out_ready_i;
  assign pop_o = ce && pop_valid_i;
  assign w     = (cfg_i.width == '0) ? NSW'(1) : cfg_i.width;

  assign d    = {pop_data_i.g[GRW-1], pop_data_i.g} - $signed({{(GRW-NSW+1){1'b0}}, cfg_i.center});
  assign ad   = d[GRW] ? (GRW+1)'(0) - d : d;
  assign zero = (ad >= {{(GRW-ADW+1){1'b0}}, w, 2'b00});

  always_comb begin
    for (int j = 0; j < XW; j++) begin
      logic [NSW:0] t;
      logic         ge;
      t         = {rem_q[j], num_q[j][XW-1]};
      ge        = (t >= {1'b0, w});
      rem_nx[j] = ge ? NSW'(t - {1'b0, w}) : t[NSW-1:0];
      num_nx[j] = {num_q[j][XW-2:0], ge};
    end
  end

  assign xx = num_q[XW] * num_q[XW];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < NSB; k++) sb_val_q[k] <= 1'b0;
      out_valid_q <= 1'b0;
    end else if (ce) begin
      sb_val_q[0] <= pop_valid_i;
      for (int k = 0; k < NSB - 1; k++) sb_val_q[k+1] <= sb_val_q[k];
      out_valid_q <= sb_val_q[NSB-1];
    end
  end

  always_ff @(posedge clk_i) begin
    if (ce) begin
      sb_q[0].zero <= zero;
      sb_q[0].cond <= pop_data_i.cond;
      for (int k = 0; k < NSB - 1; k++) begin
        sb_q[k+1].zero <= sb_q[k].zero;
        sb_q[k+1].cond <= sb_q[k].cond;
      end
      rem_q[0] <= ad[ADW-1:2];
      num_q[0] <= {ad[1:0], {(XW-2){1'b0}}};
      for (int j = 0; j < XW; j++) begin
        rem_q[j+1] <= rem_nx[j];
        num_q[j+1] <= num_nx[j];
      end
      s_q <= xx[2*XW-1:34];
    end
  end

  for (genvar i = 0; i < HN; i++) begin : g_horner
    logic [SW-1:0]     s_in;
    logic [RW-1:0]     r_in;
    logic [SW+RW-1:0]  sr;
    if (i == 0) begin : g_first
      assign s_in = s_q;
      assign r_in = Q30_ONE;
    end else begin : g_next
      assign s_in = ds_q[i-1];
      assign r_in = Q30_ONE - prod_q[i-1][RCS+RW-1:RCS];
    end
    assign sr = s_in * r_in;
    always_ff @(posedge clk_i) begin
      if (ce) begin
        p_q[i]    <= sr[SW+RW-1:30];
        ps_q[i]   <= s_in;
        prod_q[i] <= p_q[i] * RECIP[i];
        ds_q[i]   <= ps_q[i];
      end
    end
  end

  assign r_exp = Q30_ONE - prod_q[HN-1][RCS+RW-1:RCS];

  for (genvar k = 0; k < NSQ; k++) begin : g_square
    logic [RW-1:0]   r_in;
    logic [2*RW-1:0] rr;
    if (k == 0) begin : g_first
      assign r_in = r_exp;
    end else begin : g_next
      assign r_in = sq_q[k-1];
    end
    assign rr = r_in * r_in;
    always_ff @(posedge clk_i) begin
      if (ce) begin
        sq_q[k] <= rr[RW+29:30];
      end
    end
  end

  assign pm_rnd = pm_q + (GNW+RW)'(1 << 29);

  always_ff @(posedge clk_i) begin
    if (ce) begin
      pm_q           <= cfg_i.gain * sq_q[NSQ-1];
      out_pressure_q <= sb_q[NSB-1].zero ? '0 : pm_rnd[GNW+29:30];
      out_cond_q     <= sb_q[NSB-1].cond;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign out_pressure_o = out_pressure_q;
  assign out_cond_o     = out_cond_q;

endmodule

### sv/pressure_sensor_gaussian_calibration.sv
// ----------------------------------------------------------------------------
// pressure_sensor_gaussian_calibration
// Voltage sample to conductance (nS) and Gaussian-calibrated pressure (g, Q8).
// Path: 44-stage conductance divider front, then the queue, then the
//   curve back end.
// Throughput: one sample per cycle while the output is not stalled;
//   each divider stage resolves one bit.
// Reset: configuration returns to its defaults, all pipelines and the queue
//   empty; no clearing pass.
// ----------------------------------------------------------------------------
module pressure_sensor_gaussian_calibration
  import psgc_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [2:0]  cfg_idx_i,
  input  logic [20:0] cfg_wdata_i,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [15:0] s_axis_tdata,   // [11:0] voltage_mv
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [39:0] m_axis_tdata    // [17:0] pressure_q8, [39:18] conductance_ns
);

  cfg_t   cfg_q;
  logic   full, push, pop, pop_valid;
  item_t  push_data, pop_data;
  logic [GNW-1:0]  pressure;
  logic [CNDW-1:0] cond;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.gain   <= GNW'(159770);
      cfg_q.center <= NSW'(677900);
      cfg_q.width  <= NSW'(265200);
      cfg_q.vref   <= VW'(580);
      cfg_q.rf     <= RFW'(4700);
    end else if (cfg_we_i) begin
      unique case (reg_e'(cfg_idx_i))
        REG_GAIN:   cfg_q.gain   <= cfg_wdata_i[GNW-1:0];
        REG_CENTER: cfg_q.center <= cfg_wdata_i[NSW-1:0];
        REG_WIDTH:  cfg_q.width  <= cfg_wdata_i[NSW-1:0];
        REG_VREF:   cfg_q.vref   <= cfg_wdata_i[VW-1:0];
        REG_RF:     cfg_q.rf     <= cfg_wdata_i[RFW-1:0];
        default: ;
      endcase
    end
  end

  psgc_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_i        (cfg_q),
    .in_valid_i   (s_axis_tvalid),
    .in_voltage_i (s_axis_tdata[VW-1:0]),
    .in_ready_o   (s_axis_tready),
    .full_i       (full),
    .push_o       (push),
    .push_data_o  (push_data)
  );

  psgc_fifo u_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (push_data),
    .full_o      (full),
    .pop_i       (pop),
    .pop_valid_o (pop_valid),
    .pop_data_o  (pop_data)
  );

  psgc_back u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_i          (cfg_q),
    .pop_valid_i    (pop_valid),
    .pop_data_i     (pop_data),
    .pop_o          (pop),
    .out_valid_o    (m_axis_tvalid),
    .out_ready_i    (m_axis_tready),
    .out_pressure_o (pressure),
    .out_cond_o     (cond)
  );

  assign m_axis_tdata = {cond, pressure};

endmodule

### sim/pressure_sensor_gaussian_calibration_test.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// pressure_sensor_gaussian_calibration_test
// Streams voltage samples through the calibration block under several
// register settings and random stalls on both sides, predicts conductance
// and pressure per sample, and checks every result in order.
// ----------------------------------------------------------------------------
module pressure_sensor_gaussian_calibration_test;
  import psgc_pkg::*;

  localparam int LATENCY    = 108;
  localparam int IDLE_LIMIT = 20000;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        cfg_we_i = 1'b0;
  logic [2:0]  cfg_idx_i = '0;
  logic [20:0] cfg_wdata_i = '0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [15:0] s_axis_tdata = '0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [39:0] m_axis_tdata;

  typedef struct packed {
    logic [21:0] cond;
    logic [17:0] pressure;
  } reading_t;

  logic [17:0] gain_r;
  logic [20:0] center_r, width_r;
  logic [11:0] vref_r;
  logic [19:0] rf_r;

  logic [11:0] sample_q[$];
  reading_t    reading_q[$];
  int          errors = 0;
  int          idle_cycles = 0;
  bit          calm = 1'b0;
  bit          in_taken = 1'b0;
  int          hold_off = 0;
  int          send_gap = 0;
  int          recv_gap = 0;

  pressure_sensor_gaussian_calibration dut (.*);

  always #10 clk_i = ~clk_i;

  function automatic reading_t calibrate(logic [11:0] v);
    logic [63:0] vr, rf, den, diff, mag, w, ad, x, t, s, r;
    logic signed [63:0] g, d, gs;
    reading_t res;
    vr = (vref_r == 0) ? 64'd1 : 64'(vref_r);
    rf = (rf_r == 0) ? 64'd1 : 64'(rf_r);
    den = vr * rf;
    diff = (64'(v) < vr) ? vr - 64'(v) : 64'(v) - vr;
    mag = (diff * 64'd1000000000 + den / 2) / den;
    g = (64'(v) < vr) ? -$signed(mag) : $signed(mag);
    gs = (g > 2097151) ? 64'sd2097151 : (g < -2097152) ? -64'sd2097152 : g;
    res.cond = gs[21:0];
    w = (width_r == 0) ? 64'd1 : 64'(width_r);
    d = g - $signed(64'(center_r));
    ad = (d < 0) ? 64'(-d) : 64'(d);
    if (ad >= 4 * w) begin
      res.pressure = '0;
    end else begin
      x = (ad << 30) / w;
      t = (x * x) >> 30;
      s = t >> 4;
      r = 64'd1 << 30;
      for (int k = 12; k >= 1; k--) r = (64'd1 << 30) - ((s * r) >> 30) / 64'(k);
      for (int k = 0; k < 4; k++) r = (r * r) >> 30;
      res.pressure = 18'((64'(gain_r) * r + (64'd1 << 29)) >> 30);
    end
    return res;
  endfunction

  task automatic write_reg(reg_e idx, logic [20:0] val);
    @(negedge clk_i);
    cfg_we_i = 1'b1;
    cfg_idx_i = idx;
    cfg_wdata_i = val;
    @(negedge clk_i);
    cfg_we_i = 1'b0;
    case (idx)
      REG_GAIN:   gain_r = val[17:0];
      REG_CENTER: center_r = val;
      REG_WIDTH:  width_r = val;
      REG_VREF:   vref_r = val[11:0];
      REG_RF:     rf_r = val[19:0];
      default: ;
    endcase
  endtask

  task automatic drain();
    wait (sample_q.size() == 0 && !s_axis_tvalid && reading_q.size() == 0);
    repeat (LATENCY + 10) @(negedge clk_i);
  endtask

  // input transfers
  always @(posedge clk_i) begin
    in_taken <= s_axis_tvalid && s_axis_tready;
    if (s_axis_tvalid && s_axis_tready) begin
      reading_q.push_back(calibrate(s_axis_tdata[11:0]));
    end
  end

  // driver
  always @(negedge clk_i) begin
    if (!s_axis_tvalid || in_taken) begin
      if (send_gap > 0) begin
        send_gap <= send_gap - 1;
        s_axis_tvalid <= 1'b0;
      end else if (sample_q.size() > 0) begin
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= {4'b0, sample_q.pop_front()};
        if (!calm && $urandom_range(0, 7) == 0) send_gap <= $urandom_range(1, 16);
      end else begin
        s_axis_tvalid <= 1'b0;
      end
    end
  end

  // receiver stalls
  always @(negedge clk_i) begin
    if (hold_off > 0) begin
      hold_off <= hold_off - 1;
      m_axis_tready <= 1'b0;
    end else if (recv_gap > 0) begin
      recv_gap <= recv_gap - 1;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= 1'b1;
      if (!calm && $urandom_range(0, 7) == 0) recv_gap <= $urandom_range(1, 16);
    end
  end

  // monitor
  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      reading_t got, want;
      got = m_axis_tdata;
      if (reading_q.size() == 0) begin
        errors++;
        $display("%0t: unexpected result expected none actual %h", $time, m_axis_tdata);
      end else begin
        want = reading_q.pop_front();
        if (got.pressure !== want.pressure) begin
          errors++;
          $display("%0t: pressure expected %0d actual %0d", $time, want.pressure,
                   got.pressure);
        end
        if (got.cond !== want.cond) begin
          errors++;
          $display("%0t: conductance expected %0d actual %0d", $time,
                   $signed(want.cond), $signed(got.cond));
        end
      end
    end
  end

  // watchdog
  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)
        || hold_off > 0 || cfg_we_i) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  task automatic add_random(int n);
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(0, 3) == 0) sample_q.push_back(12'($urandom));
      else sample_q.push_back(12'($urandom_range(0, 1500)));
    end
  endtask

  initial begin
    gain_r = 18'd159770; center_r = 21'd677900; width_r = 21'd265200;
    vref_r = 12'd580; rf_r = 20'd4700;
    repeat (3) @(negedge clk_i);
    rst_ni = 1'b1;

    // directed: extremes, near reference, tail of curve
    sample_q.push_back(12'd0);
    sample_q.push_back(12'hFFF);
    sample_q.push_back(12'd579);
    sample_q.push_back(12'd580);
    sample_q.push_back(12'd581);
    sample_q.push_back(12'd2075);
    sample_q.push_back(12'd2076);
    sample_q.push_back(12'h555);
    sample_q.push_back(12'hAAA);
    drain();

    // zero width / reference / resistor, overflow of conductance
    write_reg(REG_WIDTH, 21'd0);
    write_reg(REG_VREF, 21'd0);
    write_reg(REG_RF, 21'd0);
    write_reg(REG_CENTER, 21'h1FFFFF);
    write_reg(REG_GAIN, 21'h3FFFF);
    sample_q.push_back(12'd0);
    sample_q.push_back(12'd1);
    sample_q.push_back(12'd2);
    sample_q.push_back(12'hFFF);
    drain();
    write_reg(REG_VREF, 21'd1);
    write_reg(REG_RF, 21'd1);
    write_reg(REG_WIDTH, 21'h1FFFFF);
    write_reg(REG_CENTER, 21'd0);
    sample_q.push_back(12'd0);
    sample_q.push_back(12'd1);
    sample_q.push_back(12'hFFF);
    drain();
    write_reg(REG_VREF, 21'hFFF);
    write_reg(REG_RF, 21'hFFFFF);
    sample_q.push_back(12'd0);
    sample_q.push_back(12'hFFF);
    sample_q.push_back(12'hFFE);
    drain();

    // defaults; long receiver hold-off while sender keeps offering
    write_reg(REG_GAIN, 21'd159770);
    write_reg(REG_CENTER, 21'd677900);
    write_reg(REG_WIDTH, 21'd265200);
    write_reg(REG_VREF, 21'd580);
    write_reg(REG_RF, 21'd4700);
    hold_off = 400;
    add_random(300);
    drain();

    // random settings
    for (int p = 0; p < 3; p++) begin
      write_reg(REG_GAIN, 21'($urandom));
      write_reg(REG_CENTER, 21'($urandom_range(0, 2000000)));
      write_reg(REG_WIDTH, 21'($urandom_range(1, 2097151)));
      write_reg(REG_VREF, 21'($urandom_range(1, 4095)));
      write_reg(REG_RF, 21'($urandom_range(1, 20000)));
      add_random(120);
      drain();
    end

    // final calm stretch at default reference, resistor, center and width
    write_reg(REG_VREF, 21'd580);
    write_reg(REG_RF, 21'd4700);
    write_reg(REG_CENTER, 21'd677900);
    write_reg(REG_WIDTH, 21'd265200);
    calm = 1'b1;
    add_random(120);
    drain();

    if (errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end
endmodule

### filelist.f
sv/psgc_pkg.sv
sv/psgc_fifo.sv
sv/psgc_front.sv
sv/psgc_back.sv
sv/pressure_sensor_gaussian_calibration.sv
sim/pressure_sensor_gaussian_calibration_test.sv
